// File: rtl/core/tst_pkg.sv
// Shared types and constants of the transaction status table.
// No dependencies; every other file of the block refers to this package.
package tst_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ID_W        = 32;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 2;

   localparam int FIRST_NORMAL_ID = 3;

   localparam logic [STATUS_W-1:0] ST_IN_PROGRESS = 2'd0;
   localparam logic [STATUS_W-1:0] ST_COMMITTED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABORTED     = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_FETCH    = 3'd0,
      MODE_COMMIT   = 3'd1,
      MODE_ABORT    = 3'd2,
      MODE_SET_IP   = 3'd3,
      MODE_ALLOC    = 3'd4,
      MODE_LAST_ID  = 3'd5
   } mode_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] wdata;
   } store_cmd_type;

endpackage

// File: rtl/core/tst_if.sv
// Request and response channel interfaces of the transaction status table.
// Depends on tst_pkg for field widths.
interface tst_req_if;
   logic                        valid;
   logic                        ready;
   logic [tst_pkg::MODE_W-1:0]  mode;
   logic [tst_pkg::ID_W-1:0]    txn_id;

   modport source (output valid, output mode, output txn_id, input ready);
   modport sink   (input valid, input mode, input txn_id, output ready);
endinterface

interface tst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tst_pkg::STATUS_W-1:0] status;
   logic                         did_commit;
   logic                         did_abort;
   logic [tst_pkg::ID_W-1:0]     id_out;
   logic                         error;

   modport source (output valid, output status, output did_commit, output did_abort,
                   output id_out, output error, input ready);
   modport sink   (input valid, input status, input did_commit, input did_abort,
                   input id_out, input error, output ready);
endinterface

// File: rtl/core/tst_store.sv
// Status memory: one status per table entry, registered read, one access per cycle.
// Sweeps every entry to in progress after reset. Depends on tst_pkg.
module tst_store (
   input  logic                          clock,
   input  logic                          reset,
   input  tst_pkg::store_cmd_type        cmd,
   output logic [tst_pkg::STATUS_W-1:0]  rd_data,
   output logic                          busy
);

   logic [tst_pkg::STATUS_W-1:0] mem [tst_pkg::TABLE_DEPTH];
   logic [tst_pkg::STATUS_W-1:0] rd_data_ff;
   logic                         clr_busy_ff;
   logic [tst_pkg::ADDR_W-1:0]   clr_addr_ff;
   logic                         clr_last;

   assign clr_last = clr_addr_ff == tst_pkg::ADDR_W'(tst_pkg::TABLE_DEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_last) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= tst_pkg::ST_IN_PROGRESS;
      end else if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// File: rtl/core/transaction_status_table_core.sv
// Transaction status table: a status per transaction id and an id allocator.
// Depends on tst_pkg, tst_if (channels) and tst_store (status memory).
//
// Usage:
//   req channel carries mode and txn_id; rsp channel returns one item per
//   request with status, did_commit, did_abort, id_out and error.
//   An item is moved when valid and ready are both high at a clock edge.
// Pipeline: the memory read and the request stage load at the accepting edge;
//   the response register loads from them once it is free or being drained
//   (advance), so a held-off response keeps the item in the request stage.
// Throughput: one item per cycle while req.ready is high (see Reset and Stall);
//   each item does at most a single read or a single write of the status memory,
//   issued in the cycle it is accepted, so a request sees every write before it.
// Reset: synchronous; the allocator restarts at id 3 and the memory is swept
//   to in progress, one entry per cycle, while req.ready stays low.
// Stall: while rsp is held off, one more item is taken into the read stage,
//   then req.ready drops until the response register drains.
module transaction_status_table_core (
   input  logic        clock,
   input  logic        reset,
   tst_req_if.sink     req,
   tst_rsp_if.source   rsp
);

   tst_pkg::store_cmd_type        cmd;
   logic [tst_pkg::STATUS_W-1:0]  rd_data;
   logic                          busy;

   logic                          accept;
   logic                          advance;

   logic                          normal;
   logic                          in_table;
   logic                          alloc_normal;
   logic                          alloc_in_table;
   logic                          dec_fetch;
   logic                          dec_error;
   logic                          dec_alloc;
   logic [tst_pkg::ID_W-1:0]      dec_id_out;

   logic [tst_pkg::ID_W-1:0]      next_id_ff;

   logic                          s1_valid_ff;
   logic                          s1_fetch_ff;
   logic                          s1_normal_ff;
   logic                          s1_in_table_ff;
   logic                          s1_error_ff;
   logic [tst_pkg::ID_W-1:0]      s1_id_out_ff;

   logic [tst_pkg::STATUS_W-1:0]  status_in;

   logic                          rsp_valid_ff;
   logic [tst_pkg::STATUS_W-1:0]  status_ff;
   logic                          did_commit_ff;
   logic                          did_abort_ff;
   logic [tst_pkg::ID_W-1:0]      id_out_ff;
   logic                          error_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy && (!s1_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   assign normal         = req.txn_id >= tst_pkg::ID_W'(tst_pkg::FIRST_NORMAL_ID);
   assign in_table       = req.txn_id < tst_pkg::ID_W'(tst_pkg::TABLE_DEPTH);
   assign alloc_normal   = next_id_ff >= tst_pkg::ID_W'(tst_pkg::FIRST_NORMAL_ID);
   assign alloc_in_table = next_id_ff < tst_pkg::ID_W'(tst_pkg::TABLE_DEPTH);

   always_comb begin
      cmd.rd_en  = 1'b0;
      cmd.wr_en  = 1'b0;
      cmd.addr   = req.txn_id[tst_pkg::ADDR_W-1:0];
      cmd.wdata  = tst_pkg::ST_IN_PROGRESS;
      dec_fetch  = 1'b0;
      dec_error  = 1'b0;
      dec_alloc  = 1'b0;
      dec_id_out = '0;
      case (req.mode)
         tst_pkg::MODE_FETCH: begin
            dec_fetch = 1'b1;
            cmd.rd_en = accept && normal && in_table;
         end
         tst_pkg::MODE_COMMIT: begin
            dec_error = !normal;
            cmd.wr_en = accept && normal && in_table;
            cmd.wdata = tst_pkg::ST_COMMITTED;
         end
         tst_pkg::MODE_ABORT: begin
            dec_error = !normal;
            cmd.wr_en = accept && normal && in_table;
            cmd.wdata = tst_pkg::ST_ABORTED;
         end
         tst_pkg::MODE_SET_IP: begin
            cmd.wr_en = accept && normal && in_table;
         end
         tst_pkg::MODE_ALLOC: begin
            dec_alloc  = 1'b1;
            dec_id_out = next_id_ff;
            dec_error  = next_id_ff == '0;
            cmd.addr   = next_id_ff[tst_pkg::ADDR_W-1:0];
            cmd.wr_en  = accept && alloc_normal && alloc_in_table;
         end
         tst_pkg::MODE_LAST_ID: begin
            dec_id_out = next_id_ff - 1'b1;
         end
         default: begin
            dec_fetch = 1'b0;
         end
      endcase
   end

   tst_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .busy    (busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= tst_pkg::ID_W'(tst_pkg::FIRST_NORMAL_ID);
      end else if (accept && dec_alloc) begin
         next_id_ff <= next_id_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_fetch_ff    <= dec_fetch;
         s1_normal_ff   <= normal;
         s1_in_table_ff <= in_table;
         s1_error_ff    <= dec_error;
         s1_id_out_ff   <= dec_id_out;
      end
   end

   always_comb begin
      if (!s1_fetch_ff) begin
         status_in = tst_pkg::ST_IN_PROGRESS;
      end else if (!s1_normal_ff) begin
         status_in = tst_pkg::ST_COMMITTED;
      end else if (!s1_in_table_ff) begin
         status_in = tst_pkg::ST_IN_PROGRESS;
      end else begin
         status_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         status_ff     <= status_in;
         did_commit_ff <= s1_fetch_ff && (status_in == tst_pkg::ST_COMMITTED);
         did_abort_ff  <= s1_fetch_ff && s1_normal_ff && (status_in == tst_pkg::ST_ABORTED);
         id_out_ff     <= s1_id_out_ff;
         error_ff      <= s1_error_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.did_commit = did_commit_ff;
   assign rsp.did_abort  = did_abort_ff;
   assign rsp.id_out     = id_out_ff;
   assign rsp.error      = error_ff;

endmodule

// File: rtl/core/tst_checker.sv
// Port-level checks of the transaction status table, bound to the top level.
// Depends on tst_pkg and transaction_status_table_core.
module tst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tst_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_did_commit,
   input logic                          rsp_did_abort,
   input logic [tst_pkg::ID_W-1:0]      rsp_id_out,
   input logic                          rsp_error
);

   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the clearing sweep");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id_out) && $stable(rsp_status))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_status == tst_pkg::ST_IN_PROGRESS
                                 && !rsp_did_commit && !rsp_did_abort)
      else $error("error item carries fetch results");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_did_commit || rsp_did_abort) |->
         (rsp_did_commit && rsp_status == tst_pkg::ST_COMMITTED && !rsp_did_abort)
         || (rsp_did_abort && rsp_status == tst_pkg::ST_ABORTED && !rsp_did_commit))
      else $error("commit or abort flag disagrees with status");

endmodule

bind transaction_status_table_core tst_checker u_tst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_did_commit (rsp.did_commit),
   .rsp_did_abort  (rsp.did_abort),
   .rsp_id_out     (rsp.id_out),
   .rsp_error      (rsp.error)
);

// File: tb/sv/transaction_status_table_checker.sv
// Scoreboard for the transaction status table: watches both channels, predicts each response.
// Depends on tst_pkg for widths, modes and status codes, and on tst_if for the channels.
module transaction_status_table_checker
   import tst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tst_req_if   req,
   tst_rsp_if   rsp,
   output int   mismatch_count,
   output int   outstanding,
   output int   checked_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                did_commit;
      logic                did_abort;
      logic [ID_W-1:0]     id_out;
      logic                error;
   } txn_outcome_t;

   logic [STATUS_W-1:0] status_table [TABLE_DEPTH];
   logic [ID_W-1:0]     next_txn_id;
   logic [ID_W-1:0]     cached_id;
   logic [STATUS_W-1:0] memo_status;
   txn_outcome_t        pending_outcomes [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      checked_count  = 0;
   end

   function automatic void store_status(input logic [ID_W-1:0] id,
                                        input logic [STATUS_W-1:0] value);
      if (id < TABLE_DEPTH) status_table[id[ADDR_W-1:0]] = value;
      if (id == cached_id) cached_id = '0;
   endfunction

   function automatic txn_outcome_t txn_outcome(input logic [MODE_W-1:0] mode,
                                                input logic [ID_W-1:0] id);
      txn_outcome_t    o;
      logic            normal;
      logic [ID_W-1:0] alloc_id;
      o      = '0;
      normal = (id >= FIRST_NORMAL_ID);
      case (mode)
         MODE_FETCH: begin
            if (!normal) o.status = ST_COMMITTED;
            else if (id == cached_id) o.status = memo_status;
            else begin
               o.status    = (id < TABLE_DEPTH) ? status_table[id[ADDR_W-1:0]]
                                                : ST_IN_PROGRESS;
               cached_id   = id;
               memo_status = o.status;
            end
            o.did_commit = (o.status == ST_COMMITTED);
            o.did_abort  = normal && (o.status == ST_ABORTED);
         end
         MODE_COMMIT, MODE_ABORT: begin
            if (!normal) o.error = 1'b1;
            else store_status(id, (mode == MODE_COMMIT) ? ST_COMMITTED : ST_ABORTED);
         end
         MODE_SET_IP: begin
            if (normal) store_status(id, ST_IN_PROGRESS);
         end
         MODE_ALLOC: begin
            alloc_id    = next_txn_id;
            next_txn_id = next_txn_id + 1;
            o.id_out    = alloc_id;
            if (alloc_id == '0) o.error = 1'b1;
            else if (alloc_id >= FIRST_NORMAL_ID) store_status(alloc_id, ST_IN_PROGRESS);
         end
         MODE_LAST_ID: begin
            o.id_out = next_txn_id - 1;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic check_field(input string field, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      txn_outcome_t want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            status_table[i] = (i < FIRST_NORMAL_ID) ? ST_COMMITTED : ST_IN_PROGRESS;
         next_txn_id = FIRST_NORMAL_ID;
         cached_id   = '0;
         memo_status = ST_IN_PROGRESS;
         pending_outcomes.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: response expected none actual status %0h id_out %0h error %0b",
                        $time, rsp.status, rsp.id_out, rsp.error);
            end else begin
               want = pending_outcomes.pop_front();
               checked_count++;
               check_field("status", ID_W'(want.status), ID_W'(rsp.status));
               check_field("did_commit", ID_W'(want.did_commit), ID_W'(rsp.did_commit));
               check_field("did_abort", ID_W'(want.did_abort), ID_W'(rsp.did_abort));
               check_field("id_out", want.id_out, rsp.id_out);
               check_field("error", ID_W'(want.error), ID_W'(rsp.error));
            end
         end
         if (req.valid && req.ready)
            pending_outcomes.push_back(txn_outcome(req.mode, req.txn_id));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// File: tb/sv/transaction_status_table_core_tb.sv
// Testbench top for transaction_status_table_core: clock, reset, request stimulus, verdict.
// Depends on tst_pkg, tst_if, the core and transaction_status_table_checker.
module transaction_status_table_core_tb;
   import tst_pkg::*;

   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int RANDOM_PER_PHASE = 145;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam logic [ID_W-1:0]   ID_MAX        = '1;

   logic clock;
   logic reset;
   int   send_idle_pct = 38;
   int   recv_idle_pct = 78;
   int   sent_count    = 0;
   int   stall_cycles  = 0;
   int   mismatch_count;
   int   outstanding;
   int   checked_count;

   tst_req_if req ();
   tst_rsp_if rsp ();

   transaction_status_table_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   transaction_status_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [ID_W-1:0] pick_id();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 10) return $urandom_range(FIRST_NORMAL_ID - 1, 0);
      if (sel < 65) return $urandom_range(80, FIRST_NORMAL_ID);
      if (sel < 75) return $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH - 6);
      if (sel < 80) return ID_MAX - $urandom_range(7);
      return $urandom();
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35) return MODE_FETCH;
      if (sel < 50) return MODE_COMMIT;
      if (sel < 62) return MODE_ABORT;
      if (sel < 72) return MODE_SET_IP;
      if (sel < 85) return MODE_ALLOC;
      if (sel < 95) return MODE_LAST_ID;
      return $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
   endfunction

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.mode   <= mode;
      req.txn_id <= id;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      sent_count++;
   endtask

   // hold off the sender until every response is back
   task automatic wait_drained();
      req.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic run_random(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RANDOM_PER_PHASE) send_item(pick_mode(), pick_id());
      wait_drained();
   endtask

   initial begin
      reset      = 1'b1;
      req.valid  = 1'b0;
      req.mode   = MODE_FETCH;
      req.txn_id = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_item(MODE_FETCH, 0);
      send_item(MODE_FETCH, 1);
      send_item(MODE_FETCH, 2);
      send_item(MODE_COMMIT, 0);
      send_item(MODE_ABORT, 2);
      send_item(MODE_SET_IP, 1);
      send_item(MODE_FETCH, 1);
      send_item(MODE_COMMIT, TABLE_DEPTH - 1);
      send_item(MODE_FETCH, TABLE_DEPTH - 1);
      send_item(MODE_ABORT, TABLE_DEPTH - 1);
      send_item(MODE_FETCH, TABLE_DEPTH - 1);
      send_item(MODE_COMMIT, TABLE_DEPTH);
      send_item(MODE_FETCH, TABLE_DEPTH);
      send_item(MODE_ABORT, ID_MAX);
      send_item(MODE_FETCH, ID_MAX);
      send_item(MODE_FETCH, 5);
      send_item(MODE_COMMIT, 5);
      send_item(MODE_FETCH, 5);
      send_item(MODE_ABORT, 5);
      send_item(MODE_FETCH, 5);
      send_item(MODE_SET_IP, 5);
      send_item(MODE_FETCH, 5);
      send_item(MODE_ALLOC, ID_MAX);
      send_item(MODE_ALLOC, 0);
      send_item(MODE_LAST_ID, ID_MAX);
      send_item(MODE_SPARE_LO, ID_MAX);
      wait_drained();

      run_random(38, 78);
      run_random(78, 38);
      run_random(0, 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d requests: directed corner ids, then random modes and ids", sent_count);
      $display("Checked %0d responses across three sender/receiver idle patterns",
               checked_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
